[rtl/scc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second chance cache set package
// Shared widths, command codes and the microcode program of the set sequencer.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int DEF_CAPACITY   = 8;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_VALUE_BITS = 64;

  localparam int DATA_W      = 64;
  localparam int CMD_W       = 2;
  localparam int SET_SIZE_W  = 4;
  localparam int OUT_CNT_W   = 4;
  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - OUT_CNT_W;

  localparam logic [SET_SIZE_W-1:0] SET_SIZE_RST = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 2'd0,
    CMD_PUT    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_READ_KEY,
    OP_COMPARE,
    OP_REF_READ_VAL,
    OP_TAKE_VAL,
    OP_MARK_MISS,
    OP_WRITE_VAL,
    OP_CLEAR,
    OP_WALK_INIT,
    OP_WALK_STEP,
    OP_READ_NEXT,
    OP_SHIFT,
    OP_DEC_COUNT,
    OP_APPEND,
    OP_OUTPUT
  } uop_e;

  typedef enum logic [3:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_I_GE_COUNT,
    COND_NO_MATCH,
    COND_DISPATCH,
    COND_OUT_BUSY,
    COND_ROOM,
    COND_REF_SET,
    COND_LAST_SLOT,
    COND_IS_PUT
  } cond_e;

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] A_RESULT   = 5'd0;
  localparam logic [PC_W-1:0] A_IDLE     = 5'd1;
  localparam logic [PC_W-1:0] A_SRCH     = 5'd2;
  localparam logic [PC_W-1:0] A_CMP      = 5'd3;
  localparam logic [PC_W-1:0] A_DISPATCH = 5'd4;
  localparam logic [PC_W-1:0] A_GET_HIT  = 5'd5;
  localparam logic [PC_W-1:0] A_GET_VAL  = 5'd6;
  localparam logic [PC_W-1:0] A_MISS     = 5'd7;
  localparam logic [PC_W-1:0] A_PUT_HIT  = 5'd8;
  localparam logic [PC_W-1:0] A_CLEAR    = 5'd9;
  localparam logic [PC_W-1:0] A_EVICT    = 5'd10;
  localparam logic [PC_W-1:0] A_WALK     = 5'd11;
  localparam logic [PC_W-1:0] A_RM_LOOP  = 5'd12;
  localparam logic [PC_W-1:0] A_RM_SHIFT = 5'd13;
  localparam logic [PC_W-1:0] A_RM_END   = 5'd14;
  localparam logic [PC_W-1:0] A_RM_RET   = 5'd15;
  localparam logic [PC_W-1:0] A_APPEND   = 5'd16;

  typedef struct packed {
    logic            accept;
    uop_e            op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Each step but dispatch jumps to target if cond holds, else falls through.
  function automatic uword_t ucode(logic [PC_W-1:0] addr);
    uword_t w;
    case (addr)
      A_RESULT:   w = '{1'b0, OP_OUTPUT,       COND_OUT_BUSY,   A_RESULT};
      A_IDLE:     w = '{1'b1, OP_LATCH,        COND_NO_INPUT,   A_IDLE};
      A_SRCH:     w = '{1'b0, OP_READ_KEY,     COND_I_GE_COUNT, A_DISPATCH};
      A_CMP:      w = '{1'b0, OP_COMPARE,      COND_NO_MATCH,   A_SRCH};
      A_DISPATCH: w = '{1'b0, OP_NONE,         COND_DISPATCH,   A_IDLE};
      A_GET_HIT:  w = '{1'b0, OP_REF_READ_VAL, COND_ALWAYS,     A_GET_VAL};
      A_GET_VAL:  w = '{1'b0, OP_TAKE_VAL,     COND_ALWAYS,     A_RESULT};
      A_MISS:     w = '{1'b0, OP_MARK_MISS,    COND_ALWAYS,     A_RESULT};
      A_PUT_HIT:  w = '{1'b0, OP_WRITE_VAL,    COND_ALWAYS,     A_RESULT};
      A_CLEAR:    w = '{1'b0, OP_CLEAR,        COND_ALWAYS,     A_RESULT};
      A_EVICT:    w = '{1'b0, OP_WALK_INIT,    COND_ROOM,       A_APPEND};
      A_WALK:     w = '{1'b0, OP_WALK_STEP,    COND_REF_SET,    A_WALK};
      A_RM_LOOP:  w = '{1'b0, OP_READ_NEXT,    COND_LAST_SLOT,  A_RM_END};
      A_RM_SHIFT: w = '{1'b0, OP_SHIFT,        COND_ALWAYS,     A_RM_LOOP};
      A_RM_END:   w = '{1'b0, OP_DEC_COUNT,    COND_IS_PUT,     A_EVICT};
      A_RM_RET:   w = '{1'b0, OP_NONE,         COND_ALWAYS,     A_RESULT};
      A_APPEND:   w = '{1'b0, OP_APPEND,       COND_ALWAYS,     A_RESULT};
      default:    w = '{1'b0, OP_NONE,         COND_ALWAYS,     A_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] dispatch_pc(cmd_e cmd, logic hit);
    logic [PC_W-1:0] pc;
    case (cmd)
      CMD_GET:    pc = hit ? A_GET_HIT : A_MISS;
      CMD_PUT:    pc = hit ? A_PUT_HIT : A_EVICT;
      CMD_DELETE: pc = hit ? A_RM_LOOP : A_MISS;
      CMD_CLEAR:  pc = A_CLEAR;
      default:    pc = A_CLEAR;
    endcase
    return pc;
  endfunction

endpackage

[rtl/second_chance_cache_set.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second chance cache set
// Fully associative set of key/value entries in insertion order with
// second chance eviction, run by a microcoded sequencer over key and value
// memories and a row of reference bit flops.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Contents
//  s_axis    in         s_axis_tvalid/tready      command, key, new_value
//  m_axis    out        m_axis_tvalid/tready      status, read_value, count
//  cfg       in         cfg_valid_i/cfg_ready_o   set_size
//
// Each item reads and compares one key per entry searched; the next transfer
// is taken after the result is loaded into m_axis. A put that evicts walks
// the reference bits from slot 0, clearing set ones, then moves each entry
// after the victim down one slot. The single read port of the key and value
// memories serialises these steps. Reset empties the set at once. A result
// waiting on m_axis holds the sequencer at its output step.
// ----------------------------------------------------------------------------
module second_chance_cache_set #(
  parameter int CAPACITY   = scc_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = scc_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = scc_pkg::DEF_VALUE_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Bits from low: key[63:0], new_value[127:64].
  input  logic [scc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Bits from low: command[1:0].
  input  logic [scc_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Bits from low: read_value[63:0], entry_count_out[67:64], zero pad.
  output logic [scc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Bits from low: status[0].
  output logic                               m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [scc_pkg::SET_SIZE_W-1:0]     cfg_data_i
);
  import scc_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [PC_W-1:0]       pc_q, pc_d;
  uword_t                uw;
  logic                  cond_hit;

  logic [SET_SIZE_W-1:0] set_size_q;
  logic [CW-1:0]         count_q, count_d;
  logic [CAPACITY-1:0]   ref_q, ref_d;
  logic                  hit_q, hit_d;
  logic [CW-1:0]         i_q, i_d;
  logic [IW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         pos_inc;
  logic [CW-1:0]         lim;

  cmd_e                  cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  status_q, status_d;
  logic [VALUE_BITS-1:0] rv_q, rv_d;

  logic                  m_valid_q, m_valid_d;
  logic                  m_status_q;
  logic [VALUE_BITS-1:0] m_rv_q;
  logic [OUT_CNT_W-1:0]  m_cnt_q;
  logic                  out_busy, out_load;

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [KEY_BITS-1:0]   key_rd_q, key_wdata;
  logic [VALUE_BITS-1:0] val_rd_q, val_wdata;
  logic                  key_we, val_we, mem_re;
  logic [IW-1:0]         mem_waddr, mem_raddr;

  assign uw            = ucode(pc_q);
  assign s_axis_tready = uw.accept;
  assign cfg_ready_o   = 1'b1;
  assign out_busy      = m_valid_q && !m_axis_tready;
  assign out_load      = (uw.op == OP_OUTPUT) && !out_busy;
  assign pos_inc       = CW'(pos_q) + CW'(1);

  always_comb begin
    if (int'(set_size_q) >= CAPACITY) begin
      lim = CW'(CAPACITY);
    end else if (set_size_q < SET_SIZE_W'(2)) begin
      lim = CW'(2);
    end else begin
      lim = CW'(set_size_q);
    end
  end

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:     cond_hit = 1'b1;
      COND_NO_INPUT:   cond_hit = !s_axis_tvalid;
      COND_I_GE_COUNT: cond_hit = (i_q >= count_q);
      COND_NO_MATCH:   cond_hit = (key_rd_q != key_q);
      COND_OUT_BUSY:   cond_hit = out_busy;
      COND_ROOM:       cond_hit = (count_q < lim);
      COND_REF_SET:    cond_hit = ref_q[pos_q];
      COND_LAST_SLOT:  cond_hit = (pos_inc >= count_q);
      COND_IS_PUT:     cond_hit = (cmd_q == CMD_PUT);
      default:         cond_hit = 1'b0;
    endcase
    if (uw.cond == COND_DISPATCH) begin
      pc_d = dispatch_pc(cmd_q, hit_q);
    end else if (cond_hit) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_comb begin
    cmd_d     = cmd_q;
    key_d     = key_q;
    val_d     = val_q;
    status_d  = status_q;
    rv_d      = rv_q;
    count_d   = count_q;
    ref_d     = ref_q;
    hit_d     = hit_q;
    i_d       = i_q;
    pos_d     = pos_q;
    key_we    = 1'b0;
    val_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pos_q;
    mem_raddr = pos_q;
    key_wdata = key_q;
    val_wdata = val_q;
    case (uw.op)
      OP_LATCH: begin
        if (s_axis_tvalid) begin
          cmd_d    = cmd_e'(s_axis_tuser);
          key_d    = s_axis_tdata[KEY_BITS-1:0];
          val_d    = s_axis_tdata[DATA_W+VALUE_BITS-1:DATA_W];
          status_d = 1'b0;
          rv_d     = '0;
          hit_d    = 1'b0;
          i_d      = '0;
        end
      end
      OP_READ_KEY: begin
        mem_re    = (i_q < count_q);
        mem_raddr = i_q[IW-1:0];
      end
      OP_COMPARE: begin
        if (key_rd_q == key_q) begin
          hit_d = 1'b1;
          pos_d = i_q[IW-1:0];
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      OP_REF_READ_VAL: begin
        ref_d[pos_q] = 1'b1;
        mem_re       = 1'b1;
      end
      OP_TAKE_VAL: rv_d = val_rd_q;
      OP_MARK_MISS: status_d = 1'b1;
      OP_WRITE_VAL: val_we = 1'b1;
      OP_CLEAR: begin
        ref_d   = '0;
        count_d = '0;
      end
      OP_WALK_INIT: pos_d = '0;
      OP_WALK_STEP: begin
        if (ref_q[pos_q]) begin
          ref_d[pos_q] = 1'b0;
          pos_d        = (pos_inc >= count_q) ? '0 : pos_inc[IW-1:0];
        end
      end
      OP_READ_NEXT: begin
        mem_re    = 1'b1;
        mem_raddr = pos_inc[IW-1:0];
      end
      OP_SHIFT: begin
        key_we       = 1'b1;
        val_we       = 1'b1;
        key_wdata    = key_rd_q;
        val_wdata    = val_rd_q;
        ref_d[pos_q] = ref_q[pos_inc[IW-1:0]];
        pos_d        = pos_inc[IW-1:0];
      end
      OP_DEC_COUNT: begin
        count_d                 = count_q - CW'(1);
        ref_d[count_d[IW-1:0]]  = 1'b0;
      end
      OP_APPEND: begin
        key_we                  = 1'b1;
        val_we                  = 1'b1;
        mem_waddr               = count_q[IW-1:0];
        ref_d[count_q[IW-1:0]]  = 1'b0;
        count_d                 = count_q + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= A_IDLE;
      set_size_q <= SET_SIZE_RST;
      count_q    <= '0;
      ref_q      <= '0;
      hit_q      <= 1'b0;
      i_q        <= '0;
      pos_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      count_q   <= count_d;
      ref_q     <= ref_d;
      hit_q     <= hit_d;
      i_q       <= i_d;
      pos_q     <= pos_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        set_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    val_q    <= val_d;
    status_q <= status_d;
    rv_q     <= rv_d;
    if (out_load) begin
      m_status_q <= status_q;
      m_rv_q     <= rv_q;
      m_cnt_q    <= OUT_CNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[mem_waddr] <= key_wdata;
    end
    if (val_we) begin
      val_mem[mem_waddr] <= val_wdata;
    end
    if (mem_re) begin
      key_rd_q <= key_mem[mem_raddr];
      val_rd_q <= val_mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_cnt_q, DATA_W'(m_rv_q)};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= CAPACITY)
    else $error("Entry count exceeds the capacity.");

  a_accept_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> pc_q == A_SRCH)
    else $error("An accepted transfer did not start the search.");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == A_WALK |-> count_q != '0)
    else $error("Eviction walk runs over an empty set.");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == A_RM_SHIFT |-> pos_inc < count_q)
    else $error("Compaction moves an entry from beyond the count.");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q == A_RESULT && out_busy |=> pc_q == A_RESULT)
    else $error("Sequencer left the output step while a result was held.");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second chance cache set testbench
// Streams get, put, delete and clear commands into the set, predicts every
// reply with a behavioral copy of the set and its second chance eviction, and
// checks each reply field by field. The set size is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import scc_pkg::*;

  localparam int SLOTS       = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_OPS   = 185;

  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] key;
    logic [63:0] value;
  } cache_op_t;

  typedef struct packed {
    logic        status;
    logic [63:0] read_value;
    logic [3:0]  count;
  } cache_reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [SET_SIZE_W-1:0]  cfg_data_i = '0;

  cache_op_t    op_queue[$];
  cache_reply_t pending_replies[$];
  logic [63:0]  key_pool[12];

  logic [63:0]           set_keys[SLOTS];
  logic [63:0]           set_values[SLOTS];
  logic                  set_refs[SLOTS];
  int                    set_count = 0;
  logic [SET_SIZE_W-1:0] set_size_reg = SET_SIZE_RST;

  logic op_taken = 1'b0;
  logic stall_on = 1'b1;
  int   in_gap = 0;
  int   out_gap = 0;
  int   error_count = 0;
  int   cycle_count = 0;

  second_chance_cache_set i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int find_key(logic [63:0] k);
    for (int i = 0; i < set_count; i++) begin
      if (set_keys[i] == k) return i;
    end
    return SLOTS;
  endfunction

  function automatic void drop_slot(int slot);
    for (int i = slot; i + 1 < set_count; i++) begin
      set_keys[i]   = set_keys[i+1];
      set_values[i] = set_values[i+1];
      set_refs[i]   = set_refs[i+1];
    end
    set_count--;
    set_refs[set_count] = 1'b0;
  endfunction

  function automatic void evict_victim();
    int hand;
    hand = 0;
    for (int steps = 0; steps < 2 * set_count + 1; steps++) begin
      if (!set_refs[hand]) break;
      set_refs[hand] = 1'b0;
      hand++;
      if (hand >= set_count) hand = 0;
    end
    drop_slot(hand);
  endfunction

  function automatic cache_reply_t cache_lookup_update(cache_op_t op);
    cache_reply_t reply;
    int           slot;
    int           limit;
    reply = '0;
    slot  = find_key(op.key);
    limit = (set_size_reg < 2) ? 2 : (set_size_reg > SLOTS) ? SLOTS : int'(set_size_reg);
    case (op.cmd)
      CMD_GET: begin
        if (slot < SLOTS) begin
          set_refs[slot]   = 1'b1;
          reply.read_value = set_values[slot];
        end else begin
          reply.status = 1'b1;
        end
      end
      CMD_PUT: begin
        if (slot < SLOTS) begin
          set_values[slot] = op.value;
        end else begin
          while (set_count >= limit && set_count > 0) evict_victim();
          set_keys[set_count]   = op.key;
          set_values[set_count] = op.value;
          set_refs[set_count]   = 1'b0;
          set_count++;
        end
      end
      CMD_DELETE: begin
        if (slot < SLOTS) drop_slot(slot);
        else reply.status = 1'b1;
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) set_refs[i] = 1'b0;
        set_count = 0;
      end
    endcase
    reply.count = set_count[3:0];
    return reply;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Prediction is made at the edge where the command transfer happens.
  always @(posedge clk_i) begin
    op_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_replies.push_back(cache_lookup_update(cache_op_t'{cmd_e'(s_axis_tuser),
          s_axis_tdata[63:0], s_axis_tdata[127:64]}));
    end
  end

  always @(negedge clk_i) begin
    cache_op_t op;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !op_taken)) begin
      if (in_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap <= $urandom_range(0, 8);
      end else if (op_queue.size() != 0) begin
        op = op_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {op.value, op.key};
        s_axis_tuser  <= op.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (out_gap != 0) begin
      m_axis_tready <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      out_gap <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cache_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        if (m_axis_tdata[63:0] !== want.read_value)
          report_mismatch("read_value", m_axis_tdata[63:0], want.read_value);
        if (m_axis_tdata[67:64] !== want.count)
          report_mismatch("entry_count", 64'(m_axis_tdata[67:64]), 64'(want.count));
      end
    end
  end

  task automatic push_op(input cmd_e cmd, input logic [63:0] key, input logic [63:0] value);
    op_queue.push_back(cache_op_t'{cmd, key, value});
  endtask

  task automatic wait_quiet();
    while (op_queue.size() != 0 || s_axis_tvalid || pending_replies.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_set_size(input logic [SET_SIZE_W-1:0] size);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    set_size_reg = size;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_random_ops(input int count);
    int          pick;
    logic [63:0] key;
    logic [63:0] value;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, 11)];
      else key = {$urandom, $urandom};
      pick = $urandom_range(0, 19);
      value = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 40) push_op(CMD_GET, key, value);
      else if (pick < 76) push_op(CMD_PUT, key, value);
      else if (pick < 98) push_op(CMD_DELETE, key, value);
      else push_op(CMD_CLEAR, key, value);
    end
  endtask

  initial begin
    logic [SET_SIZE_W-1:0] phase_sizes[7];
    phase_sizes = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd2, 4'd5};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 12; i++) key_pool[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_op(CMD_GET, key_pool[0], '1);
    push_op(CMD_DELETE, key_pool[1], '1);
    push_op(CMD_PUT, key_pool[0], '1);
    push_op(CMD_PUT, key_pool[1], '0);
    for (int i = 2; i < 8; i++) push_op(CMD_PUT, key_pool[i], {$urandom, $urandom});
    push_op(CMD_GET, key_pool[0], '0);
    push_op(CMD_GET, key_pool[3], '0);
    push_op(CMD_PUT, key_pool[1], 64'h5);
    push_op(CMD_PUT, key_pool[8], {$urandom, $urandom});
    push_op(CMD_GET, key_pool[0], '0);
    push_op(CMD_DELETE, key_pool[3], '0);
    push_op(CMD_DELETE, key_pool[3], '0);
    push_op(CMD_GET, key_pool[8], '0);
    wait_quiet();
    write_set_size(4'd3);
    push_op(CMD_PUT, key_pool[9], '1);
    push_op(CMD_GET, key_pool[9], '0);
    push_op(CMD_CLEAR, key_pool[9], '1);
    push_op(CMD_GET, key_pool[9], '0);
    wait_quiet();

    foreach (phase_sizes[p]) begin
      write_set_size(phase_sizes[p]);
      if (p == 6) stall_on = 1'b0;
      push_random_ops(PHASE_OPS);
      wait_quiet();
    end

    repeat (40) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
